>>> design/rct_pkg.sv
// Shared types and constants for the resource claim table.
`default_nettype none
package rct_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int TYPE_W  = 5;
  localparam int ID_W    = 16;
  localparam int OWNER_W = 8;
  localparam int LIM_W   = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam int LIM_HI_W   = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMITS_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITS_HIGH = 1'b1;

  localparam logic [TYPE_W-1:0] TYPE_LAST_LOW  = 5'd7;
  localparam logic [TYPE_W-1:0] TYPE_LAST_HIGH = 5'd12;
  localparam logic [TYPE_W-1:0] TYPE_FIXED     = 5'd13;
  localparam logic [LIM_W-1:0]  LIMIT_FIXED    = 8'd2;

  typedef enum logic [1:0] {
    MODE_CLAIM   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_BUSY      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                mode;
    logic [TYPE_W-1:0]    resource_type;
    logic [ID_W-1:0]      resource_id;
    logic [OWNER_W-1:0]   owner_id;
  } req_t;

  typedef struct packed {
    status_t status;
    logic    is_claimed;
  } rsp_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  etype;
    logic [ID_W-1:0]    eid;
    logic [OWNER_W-1:0] eowner;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic search_start;
    logic append;
    logic read_last;
    logic move;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    mode_t mode;
    logic  arg_ok;
    logic  search_done;
    logic  found;
    logic  owner_match;
    logic  full;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> design/resource_claim_table_unit.sv
// Top level of the resource claim table: sequencer plus table datapath.
//
//  channel   signals                          direction  beat taken when
//  request   start, busy, req                 in         start && !busy at clk rise
//  result    done, rsp                        out        done high (one cycle, no stall)
//  config    cfg_we, cfg_index, cfg_wdata     in         cfg_we high at clk rise
//
// Sequence: clear and a rejected argument are answered from the check state; claim,
// query and release first run a linear search over the table memory, one
// registered read per live entry (at most 32), plus a read and a rewrite of the
// last entry for a successful release. busy stays high from the accepted beat
// until the result beat; a new request may start in the cycle the result is
// shown.
// Reset (rst, synchronous) empties the table and sets every id limit to 255;
// the table memory itself is not cleared. The result side cannot stall.
`default_nettype none
module resource_claim_table_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire rct_pkg::req_t                   req,
  output logic                                 done,
  output rct_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_we,
  input  wire logic [rct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Command and status links between sequencer and datapath.
  rct_pkg::dp_cmd_t  cmd;
  rct_pkg::dp_stat_t stat;

  rct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp),
    .cmd   (cmd),
    .stat  (stat)
  );

  rct_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat)
  );

endmodule
`default_nettype wire

>>> design/rct_datapath.sv
// Claim table storage, limit check, linear search and entry moves.
`default_nettype none
module rct_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rct_pkg::req_t                      req,
  input  wire rct_pkg::dp_cmd_t                   cmd,
  input  wire logic                               cfg_we,
  input  wire logic [rct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output rct_pkg::dp_stat_t                       stat
);

  rct_pkg::entry_t mem [rct_pkg::MAX_ENTRIES];

  rct_pkg::req_t                       req_q;
  logic [rct_pkg::CFG_DATA_W-1:0]      limits_low;
  logic [rct_pkg::LIM_HI_W-1:0]        limits_high;
  logic [rct_pkg::CNT_W-1:0]           count;

  logic                                searching;
  logic [rct_pkg::CNT_W-1:0]           scan_ptr;
  logic                                rd_valid;
  logic [rct_pkg::IDX_W-1:0]           rd_idx;
  rct_pkg::entry_t                     rd_q;
  logic [rct_pkg::IDX_W-1:0]           rd_addr;
  logic [rct_pkg::IDX_W-1:0]           last_idx;
  logic [rct_pkg::CNT_W-1:0]           count_dec;

  logic                                search_done;
  logic                                found;
  logic [rct_pkg::IDX_W-1:0]           found_idx;
  logic [rct_pkg::OWNER_W-1:0]         found_owner;

  logic                                hit;
  logic [rct_pkg::LIM_W-1:0]           limit;
  logic                                limited;
  logic                                in_range;
  logic [rct_pkg::TYPE_W-1:0]          type_hi;

  // Per-type id limit.
  always_comb begin
    type_hi = req_q.resource_type - 5'd8;
    limited = 1'b1;
    limit   = '0;
    if (req_q.resource_type <= rct_pkg::TYPE_LAST_LOW) begin
      limit = limits_low[{req_q.resource_type[2:0], 3'b000} +: rct_pkg::LIM_W];
    end else if (req_q.resource_type <= rct_pkg::TYPE_LAST_HIGH) begin
      limit = limits_high[{type_hi[2:0], 3'b000} +: rct_pkg::LIM_W];
    end else if (req_q.resource_type == rct_pkg::TYPE_FIXED) begin
      limit = rct_pkg::LIMIT_FIXED;
    end else begin
      limited = 1'b0;
    end
    in_range = !limited || (req_q.resource_id < {8'd0, limit});
  end

  assign hit       = (rd_q.etype == req_q.resource_type) && (rd_q.eid == req_q.resource_id);
  assign count_dec = count - 1'b1;
  assign last_idx  = count_dec[rct_pkg::IDX_W-1:0];
  assign rd_addr   = cmd.read_last ? last_idx : scan_ptr[rct_pkg::IDX_W-1:0];

  always_comb begin
    stat.mode        = req_q.mode;
    stat.arg_ok      = (req_q.owner_id != '0) && in_range;
    stat.search_done = search_done;
    stat.found       = found;
    stat.owner_match = (found_owner == req_q.owner_id);
    stat.full        = (count == rct_pkg::CNT_W'(rct_pkg::MAX_ENTRIES));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits_low  <= '1;
      limits_high <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        rct_pkg::CFG_LIMITS_LOW:  limits_low  <= cfg_wdata;
        rct_pkg::CFG_LIMITS_HIGH: limits_high <= cfg_wdata[rct_pkg::LIM_HI_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (cmd.append) begin
      mem[count[rct_pkg::IDX_W-1:0]] <= '{etype:  req_q.resource_type,
                                          eid:    req_q.resource_id,
                                          eowner: req_q.owner_id};
    end else if (cmd.move) begin
      mem[found_idx] <= rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + 1'b1;
    end else if (cmd.move) begin
      count <= count_dec;
    end
  end

  // Linear search: issue one read a cycle, compare the previous one.
  always_ff @(posedge clk) begin
    if (rst) begin
      searching   <= 1'b0;
      rd_valid    <= 1'b0;
      search_done <= 1'b0;
      found       <= 1'b0;
      scan_ptr    <= '0;
    end else begin
      if (cmd.search_start) begin
        searching   <= 1'b1;
        rd_valid    <= 1'b0;
        search_done <= 1'b0;
        found       <= 1'b0;
        scan_ptr    <= '0;
      end else if (searching) begin
        if (rd_valid && hit) begin
          searching   <= 1'b0;
          rd_valid    <= 1'b0;
          search_done <= 1'b1;
          found       <= 1'b1;
          found_idx   <= rd_idx;
          found_owner <= rd_q.eowner;
        end else if (scan_ptr >= count) begin
          searching   <= 1'b0;
          rd_valid    <= 1'b0;
          search_done <= 1'b1;
          found       <= 1'b0;
        end else begin
          search_done <= 1'b0;
          rd_valid    <= 1'b1;
          rd_idx      <= scan_ptr[rct_pkg::IDX_W-1:0];
          scan_ptr    <= scan_ptr + 1'b1;
        end
      end else begin
        search_done <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/rct_ctrl.sv
// Request sequencer for the claim table.
`default_nettype none
module rct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output rct_pkg::rsp_t          rsp,
  output rct_pkg::dp_cmd_t       cmd,
  input  wire rct_pkg::dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_MOVE
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.load = (state == S_IDLE) && start;
    case (state)
      S_CHECK: begin
        if (stat.mode == rct_pkg::MODE_CLEAR) begin
          cmd.clear = 1'b1;
        end else if (stat.mode == rct_pkg::MODE_QUERY || stat.arg_ok) begin
          cmd.search_start = 1'b1;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          cmd.append    = (stat.mode == rct_pkg::MODE_CLAIM) && !stat.found && !stat.full;
          cmd.read_last = (stat.mode == rct_pkg::MODE_RELEASE) && stat.found &&
                          stat.owner_match;
        end
      end
      S_MOVE:  cmd.move = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.mode == rct_pkg::MODE_CLEAR) begin
            done           <= 1'b1;
            rsp.status     <= rct_pkg::ST_OK;
            rsp.is_claimed <= 1'b0;
            state          <= S_IDLE;
          end else if (stat.mode != rct_pkg::MODE_QUERY && !stat.arg_ok) begin
            done           <= 1'b1;
            rsp.status     <= rct_pkg::ST_INVALID;
            rsp.is_claimed <= 1'b0;
            state          <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (stat.search_done) begin
            case (stat.mode)
              rct_pkg::MODE_QUERY: begin
                done           <= 1'b1;
                rsp.status     <= rct_pkg::ST_OK;
                rsp.is_claimed <= stat.found;
                state          <= S_IDLE;
              end
              rct_pkg::MODE_CLAIM: begin
                done           <= 1'b1;
                rsp.is_claimed <= 1'b0;
                state          <= S_IDLE;
                if (stat.found) begin
                  rsp.status <= stat.owner_match ? rct_pkg::ST_OK : rct_pkg::ST_BUSY;
                end else begin
                  rsp.status <= stat.full ? rct_pkg::ST_EXHAUSTED : rct_pkg::ST_OK;
                end
              end
              default: begin
                if (stat.found && stat.owner_match) begin
                  done  <= 1'b0;
                  state <= S_MOVE;
                end else begin
                  done           <= 1'b1;
                  rsp.status     <= rct_pkg::ST_INVALID;
                  rsp.is_claimed <= 1'b0;
                  state          <= S_IDLE;
                end
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_MOVE: begin
          done           <= 1'b1;
          rsp.status     <= rct_pkg::ST_OK;
          rsp.is_claimed <= 1'b0;
          state          <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> verif/resource_claim_table_unit_tb.sv
// Self-checking testbench for resource_claim_table_unit: directed script, table fill, random phases.
`timescale 1ns / 1ps
module resource_claim_table_unit_tb;

  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SCRIPT_LEN  = 25;
  localparam int PHASES      = 4;
  localparam int RANDOM_PER  = 85;
  localparam int DRAIN_WAIT  = 40;    // longest request is a full-table release

  // One row of the directed script. When pinned is set, the answer is typed in
  // below. Otherwise the claim table tracker supplies it.
  typedef struct packed {
    rct_pkg::req_t  cmd;
    logic           pinned;
    rct_pkg::rsp_t  want;
  } script_row_t;

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  rct_pkg::req_t                    req;
  logic                             done;
  rct_pkg::rsp_t                    rsp;
  logic                             cfg_we;
  logic [rct_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [rct_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  resource_claim_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the claim table, updated on every accepted beat, and of the id limits, updated on every config write.
  logic [rct_pkg::TYPE_W-1:0]   claim_type  [rct_pkg::MAX_ENTRIES];
  logic [rct_pkg::ID_W-1:0]     claim_id    [rct_pkg::MAX_ENTRIES];
  logic [rct_pkg::OWNER_W-1:0]  claim_owner [rct_pkg::MAX_ENTRIES];
  int                           claim_count = 0;
  logic [63:0]                  lim_low_q   = '1;
  logic [rct_pkg::LIM_HI_W-1:0] lim_high_q  = '1;

  rct_pkg::rsp_t awaited_answers [$];
  logic          pin_valid = 1'b0;
  rct_pkg::rsp_t pin_rsp   = '0;
  int            fail_count = 0;
  int            cycle_count = 0;
  int            beats_taken = 0;
  int            burst_left = 0;
  int            status_seen [4] = '{0, 0, 0, 0};
  script_row_t   script [SCRIPT_LEN];

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Id range check per type: bytes of the two limit registers for types 0..12,
  // a fixed limit for type 13, anything above is unlimited.
  function automatic bit id_allowed(logic [rct_pkg::TYPE_W-1:0] t,
                                    logic [rct_pkg::ID_W-1:0] id);
    logic [rct_pkg::LIM_W-1:0] lim;
    int                        ti;
    ti = t;
    if (t <= rct_pkg::TYPE_LAST_LOW) lim = lim_low_q[8*ti +: 8];
    else if (t <= rct_pkg::TYPE_LAST_HIGH) lim = lim_high_q[8*(ti-8) +: 8];
    else if (t == rct_pkg::TYPE_FIXED) lim = rct_pkg::LIMIT_FIXED;
    else return 1'b1;
    return id < lim;
  endfunction

  // Slot holding (type, id), or claim_count when the pair is not claimed.
  function automatic int locate_claim(logic [rct_pkg::TYPE_W-1:0] t,
                                      logic [rct_pkg::ID_W-1:0] id);
    for (int i = 0; i < claim_count; i++) begin
      if (claim_type[i] == t && claim_id[i] == id) return i;
    end
    return claim_count;
  endfunction

  // Work out the answer to one request and advance the mirrored table.
  function automatic rct_pkg::rsp_t table_answer(rct_pkg::req_t r);
    rct_pkg::rsp_t o;
    int            slot;
    o.status     = rct_pkg::ST_OK;
    o.is_claimed = 1'b0;
    slot         = locate_claim(r.resource_type, r.resource_id);
    case (r.mode)
      rct_pkg::MODE_CLAIM: begin
        if (r.owner_id == '0 || !id_allowed(r.resource_type, r.resource_id)) begin
          o.status = rct_pkg::ST_INVALID;
        end else if (slot < claim_count) begin
          o.status = (claim_owner[slot] == r.owner_id) ? rct_pkg::ST_OK : rct_pkg::ST_BUSY;
        end else if (claim_count >= rct_pkg::MAX_ENTRIES) begin
          o.status = rct_pkg::ST_EXHAUSTED;
        end else begin
          claim_type[claim_count]  = r.resource_type;
          claim_id[claim_count]    = r.resource_id;
          claim_owner[claim_count] = r.owner_id;
          claim_count++;
        end
      end
      rct_pkg::MODE_RELEASE: begin
        if (r.owner_id == '0 || !id_allowed(r.resource_type, r.resource_id) ||
            slot >= claim_count || claim_owner[slot] != r.owner_id) begin
          o.status = rct_pkg::ST_INVALID;
        end else begin
          // move the last claim into the freed slot
          claim_count--;
          claim_type[slot]  = claim_type[claim_count];
          claim_id[slot]    = claim_id[claim_count];
          claim_owner[slot] = claim_owner[claim_count];
        end
      end
      rct_pkg::MODE_QUERY: o.is_claimed = (slot < claim_count);
      default:             claim_count = 0;
    endcase
    return o;
  endfunction

  function automatic rct_pkg::req_t make_req(rct_pkg::mode_t m, int t, int id, int own);
    rct_pkg::req_t r;
    r.mode          = m;
    r.resource_type = rct_pkg::TYPE_W'(t);
    r.resource_id   = rct_pkg::ID_W'(id);
    r.owner_id      = rct_pkg::OWNER_W'(own);
    return r;
  endfunction

  function automatic script_row_t row(rct_pkg::mode_t m, int t, int id, int own, bit pin,
                                      rct_pkg::status_t st, bit clm);
    script_row_t s;
    s.cmd             = make_req(m, t, id, own);
    s.pinned          = pin;
    s.want.status     = st;
    s.want.is_claimed = clm;
    return s;
  endfunction

  // Random request: small ids and few owners so claims collide. Half the time
  // aim at a live claim so releases and repeat claims get past the checks.
  function automatic rct_pkg::req_t random_request();
    int             pick;
    int             slot;
    int             t;
    int             id;
    int             own;
    rct_pkg::mode_t m;
    pick = $urandom_range(0, 99);
    m    = (pick < 40) ? rct_pkg::MODE_CLAIM : (pick < 68) ? rct_pkg::MODE_RELEASE :
           (pick < 97) ? rct_pkg::MODE_QUERY : rct_pkg::MODE_CLEAR;
    t    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 31);
    id   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom_range(0, 65535);
    pick = $urandom_range(0, 9);
    own  = (pick < 8) ? $urandom_range(1, 3) : (pick == 8) ? 0 : $urandom_range(0, 255);
    if (claim_count > 0 && m != rct_pkg::MODE_CLEAR && $urandom_range(0, 1) == 1) begin
      slot = $urandom_range(0, claim_count - 1);
      t    = claim_type[slot];
      id   = claim_id[slot];
      if (m == rct_pkg::MODE_RELEASE || $urandom_range(0, 1) == 1) own = claim_owner[slot];
    end
    return make_req(m, t, id, own);
  endfunction

  // Present one request beat and hold it until the block takes it. Start stays
  // high on return; the next call replaces the beat or drops start at its
  // falling edge. With draw set, build a random request once the gap is over.
  task automatic deliver(input rct_pkg::req_t fixed, input bit draw, input bit pin,
                         input rct_pkg::rsp_t want);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 15);
    end
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      req   = rct_pkg::req_t'(31'($urandom));   // noise on the idle bus
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    req       = draw ? random_request() : fixed;
    pin_valid = pin;
    pin_rsp   = want;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every awaited answer is back.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [rct_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Check answer beats against the queue, predict each accepted request, and
  // mirror limit writes. Pop before push: an answer and a new request can
  // share an edge.
  always @(posedge clk) begin : watch
    rct_pkg::rsp_t want;
    rct_pkg::rsp_t got;
    if (!rst) begin
      if (done) begin
        got = rsp;
        if (!$isunknown(got.status)) status_seen[got.status]++;
        if (awaited_answers.size() == 0) begin
          $display("%0t: answer beat with nothing awaited: status %0d is_claimed %0d",
                   $time, got.status, got.is_claimed);
          fail_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.is_claimed !== want.is_claimed) begin
            $display("%0t: is_claimed mismatch: expected %0d actual %0d",
                     $time, want.is_claimed, got.is_claimed);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        want = table_answer(req);
        if (pin_valid) want = pin_rsp;
        awaited_answers.push_back(want);
        beats_taken++;
      end
      if (cfg_we) begin
        case (cfg_index)
          rct_pkg::CFG_LIMITS_LOW:  lim_low_q  = cfg_wdata;
          rct_pkg::CFG_LIMITS_HIGH: lim_high_q = cfg_wdata[rct_pkg::LIM_HI_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d answers awaited",
               cycle_count, awaited_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = rct_pkg::CFG_LIMITS_LOW;
    cfg_wdata = '0;

    // Directed script, run at the reset limits of 255 for types 0..12.
    script = '{
      row(rct_pkg::MODE_QUERY,    0,     0,   0, 1, rct_pkg::ST_OK,      0),  // empty table
      row(rct_pkg::MODE_CLAIM,    0,     0,   0, 1, rct_pkg::ST_INVALID, 0),  // no owner
      row(rct_pkg::MODE_CLAIM,    0,   255,   1, 1, rct_pkg::ST_INVALID, 0),  // id at limit
      row(rct_pkg::MODE_CLAIM,    0,   254, 255, 1, rct_pkg::ST_OK,      0),  // top legal id
      row(rct_pkg::MODE_CLAIM,    0,   254, 255, 1, rct_pkg::ST_OK,      0),  // repeat
      row(rct_pkg::MODE_CLAIM,    0,   254,   1, 1, rct_pkg::ST_BUSY,    0),  // other owner
      row(rct_pkg::MODE_QUERY,    0,   254,   0, 1, rct_pkg::ST_OK,      1),
      row(rct_pkg::MODE_CLAIM,   13,     1,   7, 1, rct_pkg::ST_OK,      0),  // fixed limit
      row(rct_pkg::MODE_CLAIM,   13,     2,   7, 1, rct_pkg::ST_INVALID, 0),  // past it
      row(rct_pkg::MODE_CLAIM,   31, 65535, 128, 1, rct_pkg::ST_OK,      0),  // unlimited
      row(rct_pkg::MODE_RELEASE, 31, 65535,   3, 1, rct_pkg::ST_INVALID, 0),  // not holder
      row(rct_pkg::MODE_RELEASE,  5,     9,   3, 1, rct_pkg::ST_INVALID, 0),  // never claimed
      row(rct_pkg::MODE_RELEASE,  0,   254, 255, 1, rct_pkg::ST_OK,      0),  // last moves
      row(rct_pkg::MODE_QUERY,   31, 65535,   0, 1, rct_pkg::ST_OK,      1),
      row(rct_pkg::MODE_QUERY,    0,   254,  77, 1, rct_pkg::ST_OK,      0),
      row(rct_pkg::MODE_RELEASE, 13,     2,   7, 1, rct_pkg::ST_INVALID, 0),
      row(rct_pkg::MODE_RELEASE, 13,     1,   0, 1, rct_pkg::ST_INVALID, 0),
      row(rct_pkg::MODE_RELEASE, 12,   255,   5, 1, rct_pkg::ST_INVALID, 0),
      row(rct_pkg::MODE_CLAIM,   12,   254, 170, 0, rct_pkg::ST_OK,      0),
      row(rct_pkg::MODE_CLAIM,   16, 43690,  85, 0, rct_pkg::ST_OK,      0),
      row(rct_pkg::MODE_QUERY,   12,   254,   0, 0, rct_pkg::ST_OK,      0),
      row(rct_pkg::MODE_CLEAR,    0,     0,   0, 1, rct_pkg::ST_OK,      0),
      row(rct_pkg::MODE_QUERY,   13,     1,   0, 1, rct_pkg::ST_OK,      0),  // gone
      row(rct_pkg::MODE_QUERY,   16, 43690,   0, 1, rct_pkg::ST_OK,      0),
      row(rct_pkg::MODE_RELEASE, 13,     1,   7, 1, rct_pkg::ST_INVALID, 0)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) deliver(script[i].cmd, 1'b0, script[i].pinned, script[i].want);

    // Fill the table past capacity, then poke at it while full and after one release frees a slot.
    for (int k = 0; k < rct_pkg::MAX_ENTRIES + 2; k++) begin
      deliver(make_req(rct_pkg::MODE_CLAIM, 14 + k % 18, k * 1000 + 7, k + 1),
              1'b0, 1'b0, '0);
    end
    deliver(make_req(rct_pkg::MODE_CLAIM,   19, 5007,   6), 1'b0, 1'b0, '0);
    deliver(make_req(rct_pkg::MODE_CLAIM,   19, 5007, 200), 1'b0, 1'b0, '0);
    deliver(make_req(rct_pkg::MODE_RELEASE, 19, 5007,   6), 1'b0, 1'b0, '0);
    deliver(make_req(rct_pkg::MODE_QUERY,   19, 5007,   0), 1'b0, 1'b0, '0);
    deliver(make_req(rct_pkg::MODE_QUERY,   27, 31007,  0), 1'b0, 1'b0, '0);
    deliver(make_req(rct_pkg::MODE_CLAIM,   29, 33007, 34), 1'b0, 1'b0, '0);

    // Random phases, each under its own limit setting: all zero (every id of types
    // 0..12 rejected), all ones, small limits, and fully random bytes.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          lo = '0;
          hi = '0;
        end
        1: begin
          lo = '1;
          hi = '1;
        end
        2: begin
          lo = '0;
          hi = {$urandom, $urandom};   // bits above the register width are noise
          for (int b = 0; b < 8; b++) lo[8*b +: 8] = $urandom_range(0, 5);
          for (int b = 0; b < 5; b++) hi[8*b +: 8] = $urandom_range(0, 5);
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      write_limit(rct_pkg::CFG_LIMITS_LOW,  lo);
      write_limit(rct_pkg::CFG_LIMITS_HIGH, hi);
      for (int n = 0; n < RANDOM_PER; n++) begin
        if ($urandom_range(0, 24) == 0) settle();
        deliver('0, 1'b1, 1'b0, '0);
      end
    end

    // Drain, then give the block time to show any stray answer beat.
    settle();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d request beats: directed script, table fill, %0d limit phases.",
             beats_taken, PHASES);
    $display("Answers by status ok/invalid/busy/exhausted: %0d/%0d/%0d/%0d, %0d mismatches.",
             status_seen[rct_pkg::ST_OK], status_seen[rct_pkg::ST_INVALID],
             status_seen[rct_pkg::ST_BUSY], status_seen[rct_pkg::ST_EXHAUSTED], fail_count);
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/rct_pkg.sv
design/rct_datapath.sv
design/rct_ctrl.sv
design/resource_claim_table_unit.sv
verif/resource_claim_table_unit_tb.sv
